// File: src/cspb_pkg.sv
// Package for the clipped source-over pixel blend block.
// Holds item structs, register indexes, fixed widths and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package cspb_pkg;

    // Fixed field widths
    localparam int unsigned POS_W  = 16;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned IDX_W  = 24;
    localparam int unsigned CFG_W  = 13;
    localparam int unsigned PROD_W = 2 * CH_W;

    // Register reset values and blend constants
    localparam int unsigned WIDTH_RST  = 640;
    localparam int unsigned HEIGHT_RST = 480;
    localparam logic [CH_W-1:0]   CH_MAX   = 8'd255;
    localparam logic [PROD_W-1:0] ROUND_HALF = 16'd127;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [CH_W-1:0]         src_red;
        logic [CH_W-1:0]         src_green;
        logic [CH_W-1:0]         src_blue;
        logic [CH_W-1:0]         src_alpha;
        logic [CH_W-1:0]         dst_red;
        logic [CH_W-1:0]         dst_green;
        logic [CH_W-1:0]         dst_blue;
        logic [CH_W-1:0]         dst_alpha;
    } t_pix_in;

    typedef struct packed {
        logic             write_enable;
        logic [IDX_W-1:0] pixel_index;
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [CH_W-1:0]  out_alpha;
    } t_pix_out;

    // Load strobes for the two blend stages
    typedef struct packed {
        logic ld1;
        logic ld2;
    } t_mix_ld;

    // Exact n/255 for n up to 255*255+127: (n + 1 + n/256) / 256
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] n);
        logic [PROD_W:0] t;
        t = {1'b0, n} + 17'd1 + 17'(n[PROD_W-1:CH_W]);
        return t[PROD_W-1:CH_W];
    endfunction

endpackage

`default_nettype wire

// File: src/cspb_mix.sv
// One blend channel: (s*a + d*(255-a) + 127)/255 over two register stages.
// Depends on cspb_pkg for widths, load strobes and div255.
`default_nettype none

module cspb_mix
    import cspb_pkg::*;
(
    input  wire logic            i_clk,
    input  wire t_mix_ld         i_ld,
    input  wire logic [CH_W-1:0] i_src,
    input  wire logic [CH_W-1:0] i_dst,
    input  wire logic [CH_W-1:0] i_alpha,
    output      logic [CH_W-1:0] o_mix
);

    logic [PROD_W-1:0] r_prod_s;
    logic [PROD_W-1:0] r_prod_d;
    logic [PROD_W-1:0] r_num;
    logic [PROD_W-1:0] n_prod_s;
    logic [PROD_W-1:0] n_prod_d;
    logic [PROD_W-1:0] n_num;

    // Stage 1: both weighted products
    assign n_prod_s = PROD_W'(i_src) * PROD_W'(i_alpha);
    assign n_prod_d = PROD_W'(i_dst) * PROD_W'(CH_MAX - i_alpha);

    // Stage 2: rounded numerator, never above 255*255+127
    assign n_num = PROD_W'(r_prod_s + r_prod_d + ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_prod_s <= n_prod_s;
            r_prod_d <= n_prod_d;
        end
        if (i_ld.ld2) begin
            r_num <= n_num;
        end
    end

    // Divide by 255 feeds the output stage
    assign o_mix = div255(r_num);

endmodule

`default_nettype wire

// File: src/clipped_source_over_pixel_blend.sv
// Top level of the clipped source-over pixel blend: clip, index and blend pipeline.
// Depends on cspb_pkg and cspb_mix.
//
//  channel | direction | handshake                       | payload
//  --------+-----------+---------------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready         | i_in_item  (t_pix_in)
//  out     | output    | o_out_valid / i_out_ready       | o_out_item (t_pix_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// Three register stages: an accepted item is valid at the output once it has passed all three
// registers; one item per cycle sustained while i_out_ready stays high.
// Stage 1 clips and forms the channel products, stage 2 forms the numerators and
// row*width, stage 3 divides by 255, adds the column and selects the result.
// Reset (synchronous, active low) empties the pipeline and loads 640 x 480, saturated
// to MAX_CANVAS_DIM. A stall at the output holds the result; the stages behind it keep
// filling bubbles, so o_in_ready drops only when all three stages are full.
`default_nettype none

module clipped_source_over_pixel_blend
    import cspb_pkg::*;
#(
    parameter int unsigned MAX_CANVAS_DIM = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire t_pix_in     i_in_item,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      t_pix_out    o_out_item,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int unsigned DIM_W = $clog2(MAX_CANVAS_DIM + 1);
    localparam int unsigned CRD_W = $clog2(MAX_CANVAS_DIM);
    localparam int unsigned MUL_W = CRD_W + DIM_W;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_CANVAS_DIM);
    localparam logic [DIM_W-1:0] W_RST =
        DIM_W'((WIDTH_RST > MAX_CANVAS_DIM) ? MAX_CANVAS_DIM : WIDTH_RST);
    localparam logic [DIM_W-1:0] H_RST =
        DIM_W'((HEIGHT_RST > MAX_CANVAS_DIM) ? MAX_CANVAS_DIM : HEIGHT_RST);

    // Saturated canvas size
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] n_dim;

    // Pipeline control
    logic r1_v, r2_v, r3_v;
    logic ld1, ld2, ld3;
    t_mix_ld mix_ld;

    // Stage 1 payload
    logic             r1_we;
    logic [CRD_W-1:0] r1_x;
    logic [CRD_W-1:0] r1_y;
    logic [CH_W-1:0]  r1_dr, r1_dg, r1_db, r1_da;

    // Stage 2 payload
    logic             r2_we;
    logic [CRD_W-1:0] r2_x;
    logic [MUL_W-1:0] r2_row;
    logic [CH_W-1:0]  r2_dr, r2_dg, r2_db, r2_da;

    // Stage 3 result
    t_pix_out r3_out;
    t_pix_out n_out;

    // Clip decode
    logic x_ok, y_ok, n_we;
    logic [CH_W-1:0] mix_r, mix_g, mix_b, mix_a;

    // Saturate a written size to MAX_CANVAS_DIM
    assign n_dim = (i_cfg_data > CFG_W'(MAX_CANVAS_DIM)) ? DIM_MAX : DIM_W'(i_cfg_data);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= W_RST;
            r_height <= H_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH:  r_width  <= n_dim;
                CFG_CANVAS_HEIGHT: r_height <= n_dim;
                default: ;
            endcase
        end
    end

    // Advance each stage when it is empty or the one ahead moves
    assign ld3 = !r3_v || i_out_ready;
    assign ld2 = !r2_v || ld3;
    assign ld1 = !r1_v || ld2;
    assign o_in_ready  = ld1;
    assign o_out_valid = r3_v;
    assign o_out_item  = r3_out;
    assign mix_ld.ld1  = ld1;
    assign mix_ld.ld2  = ld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (ld1) r1_v <= i_in_valid;
            if (ld2) r2_v <= r1_v;
            if (ld3) r3_v <= r2_v;
        end
    end

    // Clip: nonnegative and below the saturated size; transparent source writes nothing
    assign x_ok = !i_in_item.pos_x[POS_W-1] &&
                  ({1'b0, i_in_item.pos_x[POS_W-2:0]} < POS_W'(r_width));
    assign y_ok = !i_in_item.pos_y[POS_W-1] &&
                  ({1'b0, i_in_item.pos_y[POS_W-2:0]} < POS_W'(r_height));
    assign n_we = x_ok && y_ok && (i_in_item.src_alpha != '0);

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_we <= n_we;
            r1_x  <= i_in_item.pos_x[CRD_W-1:0];
            r1_y  <= i_in_item.pos_y[CRD_W-1:0];
            r1_dr <= i_in_item.dst_red;
            r1_dg <= i_in_item.dst_green;
            r1_db <= i_in_item.dst_blue;
            r1_da <= i_in_item.dst_alpha;
        end
        if (ld2) begin
            r2_we  <= r1_we;
            r2_x   <= r1_x;
            r2_row <= MUL_W'(r1_y) * MUL_W'(r_width);
            r2_dr  <= r1_dr;
            r2_dg  <= r1_dg;
            r2_db  <= r1_db;
            r2_da  <= r1_da;
        end
        if (ld3) begin
            r3_out <= n_out;
        end
    end

    // Blend lanes; opaque alpha falls out exactly as a pass-through of the source
    cspb_mix u_mix_r (
        .i_clk   (i_clk),
        .i_ld    (mix_ld),
        .i_src   (i_in_item.src_red),
        .i_dst   (i_in_item.dst_red),
        .i_alpha (i_in_item.src_alpha),
        .o_mix   (mix_r)
    );

    cspb_mix u_mix_g (
        .i_clk   (i_clk),
        .i_ld    (mix_ld),
        .i_src   (i_in_item.src_green),
        .i_dst   (i_in_item.dst_green),
        .i_alpha (i_in_item.src_alpha),
        .o_mix   (mix_g)
    );

    cspb_mix u_mix_b (
        .i_clk   (i_clk),
        .i_ld    (mix_ld),
        .i_src   (i_in_item.src_blue),
        .i_dst   (i_in_item.dst_blue),
        .i_alpha (i_in_item.src_alpha),
        .o_mix   (mix_b)
    );

    // Coverage: a + (da*(255-a)+127)/255 equals a blend with a full-scale source
    cspb_mix u_mix_a (
        .i_clk   (i_clk),
        .i_ld    (mix_ld),
        .i_src   (CH_MAX),
        .i_dst   (i_in_item.dst_alpha),
        .i_alpha (i_in_item.src_alpha),
        .o_mix   (mix_a)
    );

    // Select blended result or destination copy
    always_comb begin
        n_out.write_enable = r2_we;
        if (r2_we) begin
            n_out.pixel_index = IDX_W'(r2_row + MUL_W'(r2_x));
            n_out.out_red     = mix_r;
            n_out.out_green   = mix_g;
            n_out.out_blue    = mix_b;
            n_out.out_alpha   = mix_a;
        end else begin
            n_out.pixel_index = '0;
            n_out.out_red     = r2_dr;
            n_out.out_green   = r2_dg;
            n_out.out_blue    = r2_db;
            n_out.out_alpha   = r2_da;
        end
    end

endmodule

`default_nettype wire

// File: src/cspb_checker.sv
// Port-level checker for clipped_source_over_pixel_blend, with its bind.
// Depends on cspb_pkg for the item structs.
`default_nettype none

module cspb_checker
    import cspb_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_pix_out o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // Drop the index of a pixel that is not written
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.write_enable |-> o_out_item.pixel_index == '0)
        else $error("nonzero index on a clipped item");

    // Empty the pipeline on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Take an item whenever the output stage is empty
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

endmodule

bind clipped_source_over_pixel_blend cspb_checker u_cspb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
